// File: rtl/ogs_pkg.sv
// Shared types, constants and the font table of the text glyph streamer.
package ogs_pkg;

    // Glyph geometry and panel size
    localparam int GLYPH_WIDTH  = 6;
    localparam int GLYPH_COUNT  = 95;
    localparam int PAGE_ROWS    = 8;
    localparam int FONT_COLS    = 6;
    localparam int FONT_GLYPHS  = 95;
    localparam int NCOLS        = (GLYPH_WIDTH > FONT_COLS) ? FONT_COLS : GLYPH_WIDTH;

    // Field widths
    localparam int CHAR_W    = 7;
    localparam int ROW_W     = 3;
    localparam int COL_W     = 7;
    localparam int CURCOL_W  = 8;
    localparam int BYTE_W    = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 7;

    // Bytes per item
    localparam int PAGE_CMDS = 3;
    localparam int AREA_CMDS = 6;
    localparam int MAX_BYTES = AREA_CMDS + NCOLS;
    localparam int STEP_W    = $clog2(MAX_BYTES + 1);
    localparam int GIDX_W    = $clog2(FONT_GLYPHS);
    localparam int GCOL_W    = $clog2(FONT_COLS);

    // Job queue
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Character codes and panel commands
    localparam logic [CHAR_W-1:0]   NEWLINE_CODE    = 7'd10;
    localparam logic [CHAR_W-1:0]   FIRST_PRINTABLE = 7'd32;
    localparam logic [CURCOL_W-1:0] SCREEN_LAST_COL = 8'd127;
    localparam logic [CURCOL_W-1:0] COL_SAT         = 8'd255;
    localparam logic [BYTE_W-1:0]   CMD_PAGE_BASE   = 8'hB0;
    localparam logic [BYTE_W-1:0]   CMD_COL_HI      = 8'h10;
    localparam logic [BYTE_W-1:0]   CMD_PAGE_ADDR   = 8'h22;
    localparam logic [BYTE_W-1:0]   CMD_COL_ADDR    = 8'h21;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ADDR_MODE    = 3'd0,
        CFG_AUTO_WRAP    = 3'd1,
        CFG_ORIGIN_ROW   = 3'd2,
        CFG_ORIGIN_COL   = 3'd3,
        CFG_AREA_END_ROW = 3'd4,
        CFG_AREA_END_COL = 3'd5
    } t_cfg_idx;

    typedef enum logic [1:0] {
        MV_NONE = 2'd0,
        MV_PAGE = 2'd1,
        MV_AREA = 2'd2
    } t_move;

    // One classified character, handed from front to back
    typedef struct packed {
        t_move                kind;
        logic [ROW_W-1:0]     row;
        logic [CURCOL_W-1:0]  col;
        logic [ROW_W-1:0]     end_row;
        logic [COL_W-1:0]     end_col;
        logic                 newline;
        logic [CHAR_W-1:0]    code;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    localparam logic [BYTE_W-1:0] FONT_ROM [FONT_GLYPHS][FONT_COLS] = '{
        '{8'h00,8'h00,8'h00,8'h00,8'h00,8'h00}, '{8'h00,8'h00,8'h00,8'h2f,8'h00,8'h00},
        '{8'h00,8'h00,8'h07,8'h00,8'h07,8'h00}, '{8'h00,8'h14,8'h7f,8'h14,8'h7f,8'h14},
        '{8'h00,8'h24,8'h2a,8'h7f,8'h2a,8'h12}, '{8'h00,8'h62,8'h64,8'h08,8'h13,8'h23},
        '{8'h00,8'h36,8'h49,8'h55,8'h22,8'h50}, '{8'h00,8'h00,8'h05,8'h03,8'h00,8'h00},
        '{8'h00,8'h00,8'h1c,8'h22,8'h41,8'h00}, '{8'h00,8'h00,8'h41,8'h22,8'h1c,8'h00},
        '{8'h00,8'h14,8'h08,8'h3e,8'h08,8'h14}, '{8'h00,8'h08,8'h08,8'h3e,8'h08,8'h08},
        '{8'h00,8'h00,8'h00,8'ha0,8'h60,8'h00}, '{8'h00,8'h08,8'h08,8'h08,8'h08,8'h08},
        '{8'h00,8'h00,8'h60,8'h60,8'h00,8'h00}, '{8'h00,8'h20,8'h10,8'h08,8'h04,8'h02},
        '{8'h00,8'h3e,8'h51,8'h49,8'h45,8'h3e}, '{8'h00,8'h00,8'h42,8'h7f,8'h40,8'h00},
        '{8'h00,8'h42,8'h61,8'h51,8'h49,8'h46}, '{8'h00,8'h21,8'h41,8'h45,8'h4b,8'h31},
        '{8'h00,8'h18,8'h14,8'h12,8'h7f,8'h10}, '{8'h00,8'h27,8'h45,8'h45,8'h45,8'h39},
        '{8'h00,8'h3c,8'h4a,8'h49,8'h49,8'h30}, '{8'h00,8'h01,8'h71,8'h09,8'h05,8'h03},
        '{8'h00,8'h36,8'h49,8'h49,8'h49,8'h36}, '{8'h00,8'h06,8'h49,8'h49,8'h29,8'h1e},
        '{8'h00,8'h00,8'h36,8'h36,8'h00,8'h00}, '{8'h00,8'h00,8'h56,8'h36,8'h00,8'h00},
        '{8'h00,8'h08,8'h14,8'h22,8'h41,8'h00}, '{8'h00,8'h14,8'h14,8'h14,8'h14,8'h14},
        '{8'h00,8'h00,8'h41,8'h22,8'h14,8'h08}, '{8'h00,8'h02,8'h01,8'h51,8'h09,8'h06},
        '{8'h00,8'h32,8'h49,8'h59,8'h51,8'h3e}, '{8'h00,8'h7c,8'h12,8'h11,8'h12,8'h7c},
        '{8'h00,8'h7f,8'h49,8'h49,8'h49,8'h36}, '{8'h00,8'h3e,8'h41,8'h41,8'h41,8'h22},
        '{8'h00,8'h7f,8'h41,8'h41,8'h22,8'h1c}, '{8'h00,8'h7f,8'h49,8'h49,8'h49,8'h41},
        '{8'h00,8'h7f,8'h09,8'h09,8'h09,8'h01}, '{8'h00,8'h3e,8'h41,8'h49,8'h49,8'h7a},
        '{8'h00,8'h7f,8'h08,8'h08,8'h08,8'h7f}, '{8'h00,8'h00,8'h41,8'h7f,8'h41,8'h00},
        '{8'h00,8'h20,8'h40,8'h41,8'h3f,8'h01}, '{8'h00,8'h7f,8'h08,8'h14,8'h22,8'h41},
        '{8'h00,8'h7f,8'h40,8'h40,8'h40,8'h40}, '{8'h00,8'h7f,8'h02,8'h0c,8'h02,8'h7f},
        '{8'h00,8'h7f,8'h04,8'h08,8'h10,8'h7f}, '{8'h00,8'h3e,8'h41,8'h41,8'h41,8'h3e},
        '{8'h00,8'h7f,8'h09,8'h09,8'h09,8'h06}, '{8'h00,8'h3e,8'h41,8'h51,8'h21,8'h5e},
        '{8'h00,8'h7f,8'h09,8'h19,8'h29,8'h46}, '{8'h00,8'h46,8'h49,8'h49,8'h49,8'h31},
        '{8'h00,8'h01,8'h01,8'h7f,8'h01,8'h01}, '{8'h00,8'h3f,8'h40,8'h40,8'h40,8'h3f},
        '{8'h00,8'h1f,8'h20,8'h40,8'h20,8'h1f}, '{8'h00,8'h3f,8'h40,8'h38,8'h40,8'h3f},
        '{8'h00,8'h63,8'h14,8'h08,8'h14,8'h63}, '{8'h00,8'h07,8'h08,8'h70,8'h08,8'h07},
        '{8'h00,8'h61,8'h51,8'h49,8'h45,8'h43}, '{8'h00,8'h00,8'h7f,8'h41,8'h41,8'h00},
        '{8'h00,8'h02,8'h04,8'h08,8'h10,8'h20}, '{8'h00,8'h00,8'h41,8'h41,8'h7f,8'h00},
        '{8'h00,8'h04,8'h02,8'h01,8'h02,8'h04}, '{8'h00,8'h40,8'h40,8'h40,8'h40,8'h40},
        '{8'h00,8'h00,8'h01,8'h02,8'h04,8'h00}, '{8'h00,8'h20,8'h54,8'h54,8'h54,8'h78},
        '{8'h00,8'h7f,8'h48,8'h44,8'h44,8'h38}, '{8'h00,8'h38,8'h44,8'h44,8'h44,8'h20},
        '{8'h00,8'h38,8'h44,8'h44,8'h48,8'h7f}, '{8'h00,8'h38,8'h54,8'h54,8'h54,8'h18},
        '{8'h00,8'h08,8'h7e,8'h09,8'h01,8'h02}, '{8'h00,8'h18,8'ha4,8'ha4,8'ha4,8'h7c},
        '{8'h00,8'h7f,8'h08,8'h04,8'h04,8'h78}, '{8'h00,8'h00,8'h44,8'h7d,8'h40,8'h00},
        '{8'h00,8'h40,8'h80,8'h84,8'h7d,8'h00}, '{8'h00,8'h7f,8'h10,8'h28,8'h44,8'h00},
        '{8'h00,8'h00,8'h41,8'h7f,8'h40,8'h00}, '{8'h00,8'h7c,8'h04,8'h18,8'h04,8'h78},
        '{8'h00,8'h7c,8'h08,8'h04,8'h04,8'h78}, '{8'h00,8'h38,8'h44,8'h44,8'h44,8'h38},
        '{8'h00,8'hfc,8'h24,8'h24,8'h24,8'h18}, '{8'h00,8'h18,8'h24,8'h24,8'h18,8'hfc},
        '{8'h00,8'h7c,8'h08,8'h04,8'h04,8'h08}, '{8'h00,8'h48,8'h54,8'h54,8'h54,8'h20},
        '{8'h00,8'h04,8'h3f,8'h44,8'h40,8'h20}, '{8'h00,8'h3c,8'h40,8'h40,8'h20,8'h7c},
        '{8'h00,8'h1c,8'h20,8'h40,8'h20,8'h1c}, '{8'h00,8'h3c,8'h40,8'h30,8'h40,8'h3c},
        '{8'h00,8'h44,8'h28,8'h10,8'h28,8'h44}, '{8'h00,8'h1c,8'ha0,8'ha0,8'ha0,8'h7c},
        '{8'h00,8'h44,8'h64,8'h54,8'h4c,8'h44}, '{8'h14,8'h14,8'h14,8'h14,8'h14,8'h14},
        '{8'h80,8'h80,8'h80,8'h80,8'h80,8'h80}, '{8'h01,8'h01,8'h01,8'h01,8'h01,8'h01},
        '{8'h08,8'h08,8'h08,8'h08,8'h08,8'h08}
    };

endpackage

// File: rtl/ogs_if.sv
// Channel interfaces: character input, panel byte output, register writes.
interface ogs_in_if import ogs_pkg::*;;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;
    logic              new_string;

    modport source (output valid, output char_code, output new_string, input ready);
    modport sink   (input valid, input char_code, input new_string, output ready);
endinterface

interface ogs_out_if import ogs_pkg::*;;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              is_data;
    logic              last;

    modport source (output valid, output out_byte, output is_data, output last, input ready);
    modport sink   (input valid, input out_byte, input is_data, input last, output ready);
endinterface

interface ogs_cfg_if import ogs_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] wdata;

    modport source (output valid, output index, output wdata, input ready);
    modport sink   (input valid, input index, input wdata, output ready);
endinterface

// File: rtl/ogs_front.sv
// Front end: register file, text cursor and classification of each character.
module ogs_front import ogs_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ogs_in_if.sink        i_in,
    ogs_cfg_if.sink       i_cfg,
    input  t_q_stat       i_q_stat,
    output logic          o_push,
    output t_job          o_job
);

    logic                r_addr_mode;
    logic                r_auto_wrap;
    logic [ROW_W-1:0]    r_origin_row;
    logic [COL_W-1:0]    r_origin_col;
    logic [ROW_W-1:0]    r_area_end_row;
    logic [COL_W-1:0]    r_area_end_col;

    logic [ROW_W-1:0]    r_row,  n_row;
    logic [CURCOL_W-1:0] r_col,  n_col;
    logic [ROW_W-1:0]    r_ssr,  n_ssr;
    logic [COL_W-1:0]    r_ssc,  n_ssc;

    logic                w_accept;
    logic                w_newline;
    logic                w_wrap;
    logic                w_move;
    logic [ROW_W-1:0]    w_base_row;
    logic [CURCOL_W-1:0] w_base_col;
    logic [CURCOL_W-1:0] w_limit;
    logic [CURCOL_W:0]   w_wrap_sum;
    logic [CURCOL_W:0]   w_adv;
    logic                w_row_top;
    logic [ROW_W-1:0]    w_mv_row;
    logic [CURCOL_W-1:0] w_mv_col;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = !i_q_stat.full;
    assign w_accept    = i_in.valid && !i_q_stat.full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr_mode    <= 1'b0;
            r_auto_wrap    <= 1'b0;
            r_origin_row   <= '0;
            r_origin_col   <= '0;
            r_area_end_row <= ROW_W'(PAGE_ROWS - 1);
            r_area_end_col <= COL_W'(127);
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_ADDR_MODE:    r_addr_mode    <= i_cfg.wdata[0];
                CFG_AUTO_WRAP:    r_auto_wrap    <= i_cfg.wdata[0];
                CFG_ORIGIN_ROW:   r_origin_row   <= i_cfg.wdata[ROW_W-1:0];
                CFG_ORIGIN_COL:   r_origin_col   <= i_cfg.wdata[COL_W-1:0];
                CFG_AREA_END_ROW: r_area_end_row <= i_cfg.wdata[ROW_W-1:0];
                CFG_AREA_END_COL: r_area_end_col <= i_cfg.wdata[COL_W-1:0];
                default: ;
            endcase
        end
    end

    // Reload from origin on a new string, then decide on a row move
    always_comb begin
        n_ssr      = i_in.new_string ? r_origin_row : r_ssr;
        n_ssc      = i_in.new_string ? r_origin_col : r_ssc;
        w_base_row = i_in.new_string ? r_origin_row : r_row;
        w_base_col = i_in.new_string ? {1'b0, r_origin_col} : r_col;

        w_newline  = (i_in.char_code == NEWLINE_CODE);
        w_limit    = r_addr_mode ? {1'b0, r_area_end_col} : SCREEN_LAST_COL;
        w_wrap_sum = {1'b0, w_base_col} + (CURCOL_W+1)'(GLYPH_WIDTH);
        w_wrap     = r_auto_wrap && (w_wrap_sum > {1'b0, w_limit});
        w_move     = w_newline || w_wrap;

        w_row_top  = (({1'b0, w_base_row} + (ROW_W+1)'(1)) >= (ROW_W+1)'(PAGE_ROWS));
        if (r_addr_mode) begin
            w_mv_row = (w_row_top || (w_base_row >= r_area_end_row)) ?
                       n_ssr : w_base_row + ROW_W'(1);
            w_mv_col = {1'b0, n_ssc};
        end else begin
            w_mv_row = w_row_top ? '0 : w_base_row + ROW_W'(1);
            w_mv_col = '0;
        end

        o_job.kind    = w_move ? (r_addr_mode ? MV_AREA : MV_PAGE) : MV_NONE;
        o_job.row     = w_move ? w_mv_row : w_base_row;
        o_job.col     = w_move ? w_mv_col : w_base_col;
        o_job.end_row = r_area_end_row;
        o_job.end_col = r_area_end_col;
        o_job.newline = w_newline;
        o_job.code    = i_in.char_code;

        // Advance past the glyph, saturating at COL_SAT when the column counter overflows
        w_adv = {1'b0, o_job.col} + (CURCOL_W+1)'(GLYPH_WIDTH);
        n_row = o_job.row;
        if (w_newline) begin
            n_col = o_job.col;
        end else begin
            n_col = w_adv[CURCOL_W] ? COL_SAT : w_adv[CURCOL_W-1:0];
        end
    end

    assign o_push = w_accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
            r_ssr <= '0;
            r_ssc <= '0;
        end else if (w_accept) begin
            r_row <= n_row;
            r_col <= n_col;
            r_ssr <= n_ssr;
            r_ssc <= n_ssc;
        end
    end

endmodule

// File: rtl/ogs_queue.sv
// Job queue between the front end and the byte sequencer.
module ogs_queue import ogs_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_job    i_job,
    input  logic    i_pop,
    output t_job    o_head,
    output t_q_stat o_stat
);

    t_job              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QCNT_W-1:0] r_count;

    assign o_stat.full  = (r_count == QCNT_W'(QDEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_head       = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == QPTR_W'(QDEPTH - 1)) ? '0 : r_wp + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == QPTR_W'(QDEPTH - 1)) ? '0 : r_rp + QPTR_W'(1);
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + QCNT_W'(1);
                2'b01:   r_count <= r_count - QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    ap_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stat.full |-> !i_push)
        else $error("push into full queue");

    ap_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stat.empty |-> !i_pop)
        else $error("pop from empty queue");

    ap_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QDEPTH))
        else $error("queue count out of range");

endmodule

// File: rtl/ogs_back.sv
// Back end: steps through the command and glyph bytes of each queued job.
module ogs_back import ogs_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_job      i_head,
    input  t_q_stat   i_q_stat,
    output logic      o_pop,
    ogs_out_if.source o_out
);

    logic [STEP_W-1:0] r_step;
    logic              r_valid;
    logic [BYTE_W-1:0] r_byte;
    logic              r_is_data;
    logic              r_last;

    logic              w_load;
    logic              w_have;
    logic [STEP_W-1:0] w_ncmd;
    logic [STEP_W-1:0] w_total;
    logic              w_is_data;
    logic              w_last;
    logic [BYTE_W-1:0] w_cmd;
    logic [STEP_W-1:0] w_gcol_full;
    logic [GCOL_W-1:0] w_gcol;
    logic [BYTE_W-1:0] w_gsub;
    logic [GIDX_W-1:0] w_gidx;
    logic              w_glyph_ok;

    assign w_load = !r_valid || o_out.ready;
    assign w_have = !i_q_stat.empty;

    always_comb begin
        unique case (i_head.kind)
            MV_PAGE: w_ncmd = STEP_W'(PAGE_CMDS);
            MV_AREA: w_ncmd = STEP_W'(AREA_CMDS);
            default: w_ncmd = '0;
        endcase
        w_total   = w_ncmd + (i_head.newline ? '0 : STEP_W'(NCOLS));
        w_is_data = (r_step >= w_ncmd);
        w_last    = (r_step == w_total - STEP_W'(1));

        // Command bytes of the row move
        w_cmd = '0;
        if (i_head.kind == MV_PAGE) begin
            unique case (r_step)
                STEP_W'(0): w_cmd = CMD_PAGE_BASE | BYTE_W'(i_head.row);
                STEP_W'(1): w_cmd = BYTE_W'(i_head.col[3:0]);
                STEP_W'(2): w_cmd = CMD_COL_HI | BYTE_W'(i_head.col[CURCOL_W-1:4]);
                default:    w_cmd = '0;
            endcase
        end else if (i_head.kind == MV_AREA) begin
            unique case (r_step)
                STEP_W'(0): w_cmd = CMD_PAGE_ADDR;
                STEP_W'(1): w_cmd = BYTE_W'(i_head.row);
                STEP_W'(2): w_cmd = BYTE_W'(i_head.end_row);
                STEP_W'(3): w_cmd = CMD_COL_ADDR;
                STEP_W'(4): w_cmd = i_head.col;
                STEP_W'(5): w_cmd = BYTE_W'(i_head.end_col);
                default:    w_cmd = '0;
            endcase
        end

        // Font lookup; out-of-range codes give a blank column
        w_gcol_full = r_step - w_ncmd;
        w_gcol      = w_gcol_full[GCOL_W-1:0];
        w_gsub      = BYTE_W'(i_head.code) - BYTE_W'(FIRST_PRINTABLE);
        w_gidx      = w_gsub[GIDX_W-1:0];
        w_glyph_ok  = (i_head.code >= FIRST_PRINTABLE) &&
                      (w_gsub < BYTE_W'(GLYPH_COUNT)) && (w_gsub < BYTE_W'(FONT_GLYPHS));
    end

    assign o_pop = w_load && w_have && w_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= '0;
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= w_have;
            if (w_have) begin
                r_step <= w_last ? '0 : r_step + STEP_W'(1);
            end
        end
    end

    // Output register doubles as the font ROM read register
    always_ff @(posedge i_clk) begin
        if (w_load && w_have) begin
            r_is_data <= w_is_data;
            r_last    <= w_last;
            if (w_is_data) begin
                r_byte <= w_glyph_ok ? FONT_ROM[w_gidx][w_gcol] : '0;
            end else begin
                r_byte <= w_cmd;
            end
        end
    end

    assign o_out.valid    = r_valid;
    assign o_out.out_byte = r_byte;
    assign o_out.is_data  = r_is_data;
    assign o_out.last     = r_last;

    ap_step_in_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_have |-> (r_step < w_total))
        else $error("byte step past end of job");

    ap_idle_step_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_have |-> (r_step == '0))
        else $error("step left nonzero with no job");

endmodule

// File: rtl/oled_text_glyph_streamer.sv
// A character's first byte is registered in the job queue, then in the single output register.
// One byte per cycle while the output is ready; a character gives 3 bytes (page newline), 6
// (area newline or glyph), 9 (page move plus glyph) or 12 (area move plus glyph).
// Characters are taken while earlier ones still drain, up to four waiting jobs.
// Reset (synchronous, active low): registers to their reset values, cursor to zero,
// queue and output empty; no clearing pass.
module oled_text_glyph_streamer import ogs_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ogs_in_if.sink    i_in,
    ogs_cfg_if.sink   i_cfg,
    ogs_out_if.source o_out
);

    // Front: classify each character, move the cursor, build a job
    logic    w_push;
    logic    w_pop;
    t_job    w_job;
    t_job    w_head;
    t_q_stat w_q_stat;

    ogs_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_cfg    (i_cfg),
        .i_q_stat (w_q_stat),
        .o_push   (w_push),
        .o_job    (w_job)
    );

    // Queue: hold classified jobs so input and output stall on their own
    ogs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_q_stat)
    );

    // Back: advance through command then glyph bytes, drop the job on its last byte
    ogs_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (w_head),
        .i_q_stat (w_q_stat),
        .o_pop    (w_pop),
        .o_out    (o_out)
    );

endmodule
